// ===== design/assert_macros.svh =====
// Assertion macros for the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== design/tlvp_pkg.sv =====
// Shared types and codes for the TLV payload stream parser.
// Used by every module of the block and by its checker; depends on nothing.
package tlvp_pkg;

   localparam int ByteW   = 8;
   localparam int LenW    = 16;
   localparam int RoleW   = 3;
   localparam int StatusW = 3;
   localparam int PhaseW  = 3;

   // parser phases
   localparam logic [PhaseW-1:0] PH_LEN_HI = 3'd0;
   localparam logic [PhaseW-1:0] PH_LEN_LO = 3'd1;
   localparam logic [PhaseW-1:0] PH_TYPE   = 3'd2;
   localparam logic [PhaseW-1:0] PH_LEN    = 3'd3;
   localparam logic [PhaseW-1:0] PH_VALUE  = 3'd4;
   localparam logic [PhaseW-1:0] PH_TRAIL  = 3'd5;
   localparam logic [PhaseW-1:0] PH_ERROR  = 3'd6;

   // byte roles
   localparam logic [RoleW-1:0] ROLE_HDR   = 3'd0;
   localparam logic [RoleW-1:0] ROLE_TYPE  = 3'd1;
   localparam logic [RoleW-1:0] ROLE_LEN   = 3'd2;
   localparam logic [RoleW-1:0] ROLE_VALUE = 3'd3;
   localparam logic [RoleW-1:0] ROLE_TRAIL = 3'd4;
   localparam logic [RoleW-1:0] ROLE_ERR   = 3'd5;

   // buffer status
   localparam logic [StatusW-1:0] ST_RUN     = 3'd0;
   localparam logic [StatusW-1:0] ST_OK      = 3'd1;
   localparam logic [StatusW-1:0] ST_SHORT   = 3'd2;
   localparam logic [StatusW-1:0] ST_HDRCUT  = 3'd3;
   localparam logic [StatusW-1:0] ST_OVERRUN = 3'd4;

   typedef struct packed {
      logic [ByteW-1:0] data_byte;
      logic             last_byte;
   } req_item_type;

   typedef struct packed {
      logic [RoleW-1:0]   byte_role;
      logic [ByteW-1:0]   item_type;
      logic [ByteW-1:0]   value_byte;
      logic [ByteW-1:0]   value_index;
      logic               item_done;
      logic               buffer_done;
      logic [StatusW-1:0] parse_status;
   } rsp_item_type;

   typedef struct packed {
      logic fire;    // request moves into the result register this cycle
   } pipe_ctl_type;

endpackage

// ===== design/tlv_payload_stream_parser.sv =====
// TLV payload stream parser: takes a buffer one byte per request and gives one
// result per byte. The first two bytes of a buffer are a big-endian payload
// length P; the next P bytes are items of a type byte, a length byte L and L
// value bytes. Each result tells the byte's role (header, type, length, value,
// trailing, after error), the current item type, the value byte and its index
// within the item, and whether the byte completes an item. The result for the
// byte marked by req_tlast carries rsp_tlast and the buffer status: ok, short
// buffer (takes precedence), item header cut or value overrun; the parser then
// starts over for the next buffer. Throughput is one byte per clock while the
// result register can take it: a request passes through an input register, then
// the parse step that updates the phase and counters into the result register.
// The parse step is the recurrence that bounds the rate, since each byte's role
// depends on the state the previous byte left. Both sides may stall freely.
// Depends on tlvp_pkg, tlvp_in_reg, tlvp_step and tlvp_out_reg.
module tlv_payload_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] item_type, [15:8] value_byte,
                                    // [23:16] value_index, [24] item_done,
                                    // [27:25] parse_status, [31:28] zero
   output logic [2:0]  rsp_tuser,   // [2:0] byte_role
   output logic        rsp_tlast    // buffer_done
);
   import tlvp_pkg::*;

   req_item_type req_item;
   req_item_type held_item;
   rsp_item_type step_result;
   rsp_item_type rsp_item;
   pipe_ctl_type ctl;
   logic         out_ready;

   // pack the request
   assign req_item.data_byte = req_tdata;
   assign req_item.last_byte = req_tlast;

   tlvp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .out_ready  (out_ready),
      .held_item  (held_item),
      .ctl        (ctl)
   );

   // parse one byte and advance the state whenever the request moves on
   tlvp_step u_step (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .item   (held_item),
      .result (step_result)
   );

   tlvp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .result     (step_result),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   // unpack the result onto the stream
   assign rsp_tdata = {4'b0000, rsp_item.parse_status, rsp_item.item_done,
                       rsp_item.value_index, rsp_item.value_byte, rsp_item.item_type};
   assign rsp_tuser = rsp_item.byte_role;
   assign rsp_tlast = rsp_item.buffer_done;

endmodule

// ===== design/tlvp_in_reg.sv =====
// Input register of the TLV parser: takes one request per cycle while the result register can accept.
// Depends on tlvp_pkg.
module tlvp_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tlvp_pkg::req_item_type req_item,
   input  logic                  out_ready,
   output tlvp_pkg::req_item_type held_item,
   output tlvp_pkg::pipe_ctl_type ctl
);
   import tlvp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign ctl.fire   = valid_ff & out_ready;
   assign req_tready = ~valid_ff | out_ready;
   assign take       = req_tvalid & req_tready;
   assign held_item  = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (ctl.fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== design/tlvp_step.sv =====
// Per-byte parse step: phase register, counters and the result of one byte.
// Depends on tlvp_pkg.
module tlvp_step (
   input  logic                   clock,
   input  logic                   reset,
   input  tlvp_pkg::pipe_ctl_type ctl,
   input  tlvp_pkg::req_item_type item,
   output tlvp_pkg::rsp_item_type result
);
   import tlvp_pkg::*;

   logic [PhaseW-1:0]  phase_ff,   phase_in;
   logic [ByteW-1:0]   len_hi_ff,  len_hi_in;
   logic [LenW-1:0]    payload_ff, payload_in;
   logic [ByteW-1:0]   vleft_ff,   vleft_in;
   logic [ByteW-1:0]   vpos_ff,    vpos_in;
   logic [ByteW-1:0]   ctype_ff,   ctype_in;
   logic [StatusW-1:0] err_ff,     err_in;

   logic [PhaseW-1:0]  phase_nx;
   logic [LenW-1:0]    payload_nx;
   logic [ByteW-1:0]   ctype_nx;
   logic [StatusW-1:0] err_nx;
   logic [LenW-1:0]    payload_dec;
   logic [LenW-1:0]    full_len;
   logic [ByteW-1:0]   vleft_dec;
   logic               complete;
   logic [ByteW-1:0]   b;

   assign b           = item.data_byte;
   assign payload_dec = payload_ff - 1'b1;
   assign full_len    = {len_hi_ff, b};
   assign vleft_dec   = vleft_ff - 1'b1;

   always_comb begin
      phase_nx   = phase_ff;
      len_hi_in  = len_hi_ff;
      payload_nx = payload_ff;
      vleft_in   = vleft_ff;
      vpos_in    = vpos_ff;
      ctype_nx   = ctype_ff;
      err_nx     = err_ff;
      result     = '0;
      result.byte_role = ROLE_ERR;

      case (phase_ff)
         PH_LEN_HI: begin
            result.byte_role = ROLE_HDR;
            len_hi_in = b;
            phase_nx  = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            result.byte_role = ROLE_HDR;
            payload_nx = full_len;
            phase_nx   = (full_len == '0) ? PH_TRAIL : PH_TYPE;
         end
         PH_TYPE: begin
            result.byte_role = ROLE_TYPE;
            ctype_nx   = b;
            payload_nx = payload_dec;
            if (payload_ff < LenW'(2)) begin
               err_nx   = ST_HDRCUT;
               phase_nx = PH_ERROR;
            end else begin
               phase_nx = PH_LEN;
            end
         end
         PH_LEN: begin
            result.byte_role = ROLE_LEN;
            payload_nx = payload_dec;
            if ({{(LenW-ByteW){1'b0}}, b} > payload_dec) begin
               err_nx   = ST_OVERRUN;
               phase_nx = PH_ERROR;
            end else if (b == '0) begin
               result.item_done = 1'b1;
               phase_nx = (payload_dec == '0) ? PH_TRAIL : PH_TYPE;
            end else begin
               vleft_in = b;
               vpos_in  = '0;
               phase_nx = PH_VALUE;
            end
         end
         PH_VALUE: begin
            result.byte_role   = ROLE_VALUE;
            result.value_byte  = b;
            result.value_index = vpos_ff;
            vpos_in    = vpos_ff + 1'b1;
            vleft_in   = vleft_dec;
            payload_nx = payload_dec;
            if (vleft_dec == '0) begin
               result.item_done = 1'b1;
               phase_nx = (payload_dec == '0) ? PH_TRAIL : PH_TYPE;
            end
         end
         PH_TRAIL: begin
            result.byte_role = ROLE_TRAIL;
         end
         default: begin
            // after an error: keep counting payload so a short buffer still shows
            result.byte_role = ROLE_ERR;
            phase_nx = PH_ERROR;
            if (payload_ff != '0) begin
               payload_nx = payload_dec;
            end
         end
      endcase

      result.item_type   = ctype_nx;
      result.buffer_done = item.last_byte;
      complete = (phase_nx == PH_TRAIL) || ((phase_nx == PH_ERROR) && (payload_nx == '0));
      if (item.last_byte) begin
         if (!complete) begin
            result.parse_status = ST_SHORT;
         end else if (err_nx != ST_RUN) begin
            result.parse_status = err_nx;
         end else begin
            result.parse_status = ST_OK;
         end
      end

      phase_in   = phase_nx;
      payload_in = payload_nx;
      ctype_in   = ctype_nx;
      err_in     = err_nx;
      // last byte: drop all state back to the start of a buffer
      if (item.last_byte) begin
         phase_in   = PH_LEN_HI;
         len_hi_in  = '0;
         payload_in = '0;
         vleft_in   = '0;
         vpos_in    = '0;
         ctype_in   = '0;
         err_in     = ST_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_LEN_HI;
         len_hi_ff  <= '0;
         payload_ff <= '0;
         vleft_ff   <= '0;
         vpos_ff    <= '0;
         ctype_ff   <= '0;
         err_ff     <= ST_RUN;
      end else if (ctl.fire) begin
         phase_ff   <= phase_in;
         len_hi_ff  <= len_hi_in;
         payload_ff <= payload_in;
         vleft_ff   <= vleft_in;
         vpos_ff    <= vpos_in;
         ctype_ff   <= ctype_in;
         err_ff     <= err_in;
      end
   end

endmodule

// ===== design/tlvp_out_reg.sv =====
// Result register of the TLV parser, holds a result until it is taken.
// Depends on tlvp_pkg.
module tlvp_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  tlvp_pkg::pipe_ctl_type ctl,
   input  tlvp_pkg::rsp_item_type result,
   output logic                   out_ready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output tlvp_pkg::rsp_item_type rsp_item
);
   import tlvp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign out_ready  = ~valid_ff | rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.fire) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         item_ff <= result;
      end
   end

endmodule

// ===== design/tlvp_checker.sv =====
// Port-level checks for the TLV payload stream parser, bound to the top level.
// Depends on tlvp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tlvp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import tlvp_pkg::*;

   logic [StatusW-1:0] status;
   logic [35:0]        rsp_bus;
   logic               stalled;
   logic               is_value;
   logic               done_ok;

   assign status     = rsp_tdata[27:25];
   assign rsp_bus    = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign stalled    = rsp_tvalid & ~rsp_tready;
   assign is_value   = (rsp_tuser == ROLE_VALUE);
   assign done_ok    = (rsp_tuser == ROLE_LEN) || (rsp_tuser == ROLE_VALUE);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_bus))
   `ASSERT_IMPLY(a_run_midbuf, clock, reset, rsp_tvalid && !rsp_tlast, status == ST_RUN)
   `ASSERT_IMPLY(a_final_status, clock, reset, rsp_tvalid && rsp_tlast, status != ST_RUN)
   `ASSERT_IMPLY(a_value_zero, clock, reset, rsp_tvalid && !is_value, rsp_tdata[23:8] == 16'h0000)
   `ASSERT_IMPLY(a_done_role, clock, reset, rsp_tvalid && rsp_tdata[24], done_ok)

endmodule

bind tlv_payload_stream_parser tlvp_checker u_tlvp_checker (.*);
